// ===== design/g4m_pkg.sv =====
// ----------------------------------------------------------------------------
// g4m_pkg
// Shared types, command codes and matrix helpers for the 4x4 GF(2) matrix ALU.
// ----------------------------------------------------------------------------
package g4m_pkg;

    localparam int unsigned DIM   = 4;
    localparam int unsigned COL_W = 2;

    localparam logic [1:0] CMD_MUL  = 2'd0;
    localparam logic [1:0] CMD_XP   = 2'd1;
    localparam logic [1:0] CMD_INV  = 2'd2;
    localparam logic [1:0] CMD_RANK = 2'd3;

    // low nibble: working row, high nibble: identity side of the augmented matrix
    typedef logic [7:0] row_t;

    typedef struct packed {
        logic [1:0]         cmd;
        row_t [DIM-1:0]     rows;
        logic [2:0]         rank;
        logic               sing;
    } cell_data_t;

    // product over GF(2): AND products, XOR sums
    function automatic logic [15:0] gf2_mul(input logic [15:0] a, input logic [15:0] b);
        logic [15:0] z;
        logic        acc;
        z = '0;
        for (int i = 0; i < DIM; i++) begin
            for (int j = 0; j < DIM; j++) begin
                acc = 1'b0;
                for (int k = 0; k < DIM; k++) begin
                    acc = acc ^ (a[DIM*i+k] & b[DIM*k+j]);
                end
                z[DIM*i+j] = acc;
            end
        end
        return z;
    endfunction

    function automatic logic [15:0] gf2_xp(input logic [15:0] a);
        logic [15:0] z;
        z = '0;
        for (int i = 0; i < DIM; i++) begin
            for (int j = 0; j < DIM; j++) begin
                z[DIM*j+i] = a[DIM*i+j];
            end
        end
        return z;
    endfunction

endpackage

// ===== design/g4m_in_if.sv =====
// ----------------------------------------------------------------------------
// g4m_in_if
// Command channel: one command and two packed 4x4 matrices per transfer.
// ----------------------------------------------------------------------------
interface g4m_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [15:0] operand_a;
    logic [15:0] operand_b;

    modport source (output valid, output command, output operand_a, output operand_b,
                    input ready);
    modport sink   (input valid, input command, input operand_a, input operand_b,
                    output ready);
endinterface

// ===== design/g4m_out_if.sv =====
// ----------------------------------------------------------------------------
// g4m_out_if
// Result channel: matrix, rank and singular flag per transfer.
// ----------------------------------------------------------------------------
interface g4m_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] matrix_out;
    logic [2:0]  rank_out;
    logic        singular;

    modport source (output valid, output matrix_out, output rank_out, output singular,
                    input ready);
    modport sink   (input valid, input matrix_out, input rank_out, input singular,
                    output ready);
endinterface

// ===== design/g4m_cell.sv =====
// ----------------------------------------------------------------------------
// g4m_cell
// One elimination cell: pivot search, row swap and row clear for one column.
// ----------------------------------------------------------------------------
module g4m_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [1:0]             col,
    input  logic                   up_valid,
    input  g4m_pkg::cell_data_t    up_data,
    output logic                   take,
    output logic                   valid,
    output g4m_pkg::cell_data_t    data,
    input  logic                   down_take
);

    logic                valid_reg, valid_next;
    g4m_pkg::cell_data_t data_reg, data_next;

    always_comb
    begin
        logic [1:0]                       piv;
        logic                             found;
        logic [1:0]                       kk;
        logic                             keep;
        g4m_pkg::row_t                    prow;
        g4m_pkg::row_t [g4m_pkg::DIM-1:0] sw;
        piv   = 2'd0;
        found = 1'b0;
        kk    = up_data.rank[1:0];
        for (int i = g4m_pkg::DIM - 1; i >= 0; i--)
        begin
            if ((i >= int'(up_data.rank)) && up_data.rows[i][{1'b0, col}])
            begin
                piv   = 2'(i);
                found = 1'b1;
            end
        end
        prow = up_data.rows[piv];
        // swap pivot row into place
        for (int t = 0; t < g4m_pkg::DIM; t++)
        begin
            if (2'(t) == kk)
                sw[t] = prow;
            else if (2'(t) == piv)
                sw[t] = up_data.rows[kk];
            else
                sw[t] = up_data.rows[t];
        end
        // inverse clears every other row, rank only the rows below
        for (int t = 0; t < g4m_pkg::DIM; t++)
        begin
            keep = (up_data.cmd == g4m_pkg::CMD_INV) ? (2'(t) != kk) : (2'(t) > kk);
            if (found && keep && sw[t][{1'b0, col}])
                sw[t] = sw[t] ^ prow;
        end

        data_next = up_data;
        if (up_data.cmd[1])
        begin
            if (found)
            begin
                data_next.rows = sw;
                data_next.rank = up_data.rank + 3'd1;
            end
            else if (up_data.cmd == g4m_pkg::CMD_INV)
            begin
                data_next.sing = 1'b1;
            end
        end
    end

    assign take       = !valid_reg || down_take;
    assign valid_next = take ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take && up_valid)
            data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

// ===== design/gf2_matrix4_alu.sv =====
// ----------------------------------------------------------------------------
// gf2_matrix4_alu
// 4x4 GF(2) matrix ALU: multiply, transpose, inverse and rank in a cell chain.
// ----------------------------------------------------------------------------
//  channel   dir  payload                              handshake
//  in_ch     in   command, operand_a, operand_b        valid / ready
//  out_ch    out  matrix_out, rank_out, singular       valid / ready
//
//  four register stages, one cell per column: an input transfer is registered
//  in each cell in column order, and the last cell is the output register
//  one transfer per cycle sustained while out_ch is ready; each cell holds one item in flight
//  a stalled output backs up cell by cell; a cell takes new data when it is
//  empty or its neighbor takes its item
//  rst_n clears only the valid bits of the cells
module gf2_matrix4_alu (
    input  logic        clk,
    input  logic        rst_n,
    g4m_in_if.sink      in_ch,
    g4m_out_if.source   out_ch
);

    localparam int unsigned N = g4m_pkg::DIM;

    g4m_pkg::cell_data_t        seed;
    g4m_pkg::cell_data_t [N:0]  chain_data;
    logic [N:0]                 chain_valid;
    logic [N:0]                 chain_take;
    logic [15:0]                prod;
    logic [15:0]                xpose;

    // multiply and transpose finish here and ride the chain packed in low nibbles
    assign prod  = g4m_pkg::gf2_mul(in_ch.operand_a, in_ch.operand_b);
    assign xpose = g4m_pkg::gf2_xp(in_ch.operand_a);

    always_comb
    begin
        seed      = '0;
        seed.cmd  = in_ch.command;
        for (int i = 0; i < N; i++)
        begin
            case (in_ch.command)
                g4m_pkg::CMD_MUL:  seed.rows[i] = {4'd0, prod[4*i +: 4]};
                g4m_pkg::CMD_XP:   seed.rows[i] = {4'd0, xpose[4*i +: 4]};
                // augment with identity for the Gauss-Jordan pass
                default:           seed.rows[i] = {4'(1 << i), in_ch.operand_a[4*i +: 4]};
            endcase
        end
    end

    assign chain_data[0]  = seed;
    assign chain_valid[0] = in_ch.valid;
    assign in_ch.ready    = chain_take[0];

    for (genvar g = 0; g < N; g++)
    begin : g_cell
        g4m_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .col       (g4m_pkg::COL_W'(g)),
            .up_valid  (chain_valid[g]),
            .up_data   (chain_data[g]),
            .take      (chain_take[g]),
            .valid     (chain_valid[g+1]),
            .data      (chain_data[g+1]),
            .down_take (chain_take[g+1])
        );
    end

    // last cell is the output register
    assign chain_take[N] = out_ch.ready;
    assign out_ch.valid  = chain_valid[N];

    always_comb
    begin
        g4m_pkg::cell_data_t last;
        last              = chain_data[N];
        out_ch.matrix_out = '0;
        out_ch.rank_out   = '0;
        out_ch.singular   = 1'b0;
        case (last.cmd)
            g4m_pkg::CMD_MUL,
            g4m_pkg::CMD_XP:
            begin
                for (int i = 0; i < N; i++)
                    out_ch.matrix_out[4*i +: 4] = last.rows[i][3:0];
            end
            g4m_pkg::CMD_INV:
            begin
                out_ch.singular = last.sing;
                if (!last.sing)
                begin
                    for (int i = 0; i < N; i++)
                        out_ch.matrix_out[4*i +: 4] = last.rows[i][7:4];
                end
            end
            default:
                out_ch.rank_out = last.rank;
        endcase
    end

endmodule

// ===== design/g4m_checker.sv =====
// ----------------------------------------------------------------------------
// g4m_checker
// Port-level checks for the matrix ALU, bound to the top level.
// ----------------------------------------------------------------------------
module g4m_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] matrix_out,
    input logic [2:0]  rank_out,
    input logic        singular
);

    // a stalled result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(matrix_out)
            && $stable(rank_out) && $stable(singular))
        else $error("result changed while stalled");

    // nothing queued at the output means the chain can take a transfer
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && singular |-> matrix_out == 16'd0 && rank_out == 3'd0)
        else $error("singular result carries data");

    a_rank_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rank_out != 3'd0 |-> matrix_out == 16'd0 && !singular)
        else $error("rank result carries a matrix");

    a_rank_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> rank_out <= 3'd4)
        else $error("rank above four");

endmodule

bind gf2_matrix4_alu g4m_checker u_g4m_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .matrix_out (out_ch.matrix_out),
    .rank_out   (out_ch.rank_out),
    .singular   (out_ch.singular)
);
